// ----- rtl/core/fpa_pkg.sv -----
package fpa_pkg;
    localparam int FRAC_BITS_DEF = 8;
    localparam int W = 32;
    localparam int MAG_W = 64;

    typedef enum logic [3:0] {
        K_ADD = 4'd0, K_SUB = 4'd1, K_MUL = 4'd2, K_DIV = 4'd3, K_MIN = 4'd4,
        K_MAX = 4'd5, K_INC = 4'd6, K_DEC = 4'd7, K_TOINT = 4'd8, K_FROMINT = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIVZ = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_raw;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic [1:0]         status;
    } t_out;

    // Item context carried alongside the divider chain.
    typedef struct packed {
        logic               valid;
        logic [3:0]         kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               neg;
    } t_ctx;

    function automatic t_out sat(input logic signed [65:0] x, input t_out o);
        t_out r;
        r = o;
        if (x > 66'sd2147483647) begin
            r.result_raw = 32'sh7FFFFFFF;
            r.status = ST_OVF;
        end else if (x < -66'sd2147483648) begin
            r.result_raw = 32'sh80000000;
            r.status = ST_OVF;
        end else begin
            r.result_raw = x[31:0];
        end
        return r;
    endfunction
endpackage

// ----- rtl/core/fpa_cell.sv -----
module fpa_cell import fpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctx             i_ctx,
    input  logic [MAG_W-1:0] i_rem,
    input  logic [MAG_W-1:0] i_num,
    input  logic [W-1:0]     i_quo,
    output t_ctx             o_ctx,
    output logic [MAG_W-1:0] o_rem,
    output logic [MAG_W-1:0] o_num,
    output logic [W-1:0]     o_quo
);
    // One restoring step of the long division: a single quotient bit.
    logic [MAG_W-1:0] n_rem;
    logic [MAG_W-1:0] trial;
    logic [MAG_W-1:0] dmag;

    always_comb begin
        dmag  = {{(MAG_W-W){1'b0}}, (i_ctx.b < 0) ? -i_ctx.b : i_ctx.b};
        n_rem = {i_rem[MAG_W-2:0], i_num[MAG_W-1]};
        trial = n_rem - dmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctx.valid <= 1'b0;
        end else begin
            o_ctx.valid <= i_ctx.valid;
        end
        o_ctx.kind <= i_ctx.kind;
        o_ctx.a    <= i_ctx.a;
        o_ctx.b    <= i_ctx.b;
        o_ctx.neg  <= i_ctx.neg;
        o_num      <= {i_num[MAG_W-2:0], 1'b0};
        if (n_rem >= dmag) begin
            o_rem <= trial;
            o_quo <= {i_quo[W-2:0], 1'b1};
        end else begin
            o_rem <= n_rem;
            o_quo <= {i_quo[W-2:0], 1'b0};
        end
    end
endmodule

// ----- rtl/core/fixed_point_alu.sv -----
// Signed fixed-point ALU on 32-bit raw words with FRAC_BITS fraction bits.
// A word is taken on a rising edge where i_start is high and o_busy is low.
// o_busy is held low, so a new word can enter on every cycle.
// Each word yields exactly one result word, shown for one cycle with
// o_done high. The receiver cannot stall and must take it that cycle.
// Every operation has the same latency so results leave in order:
// each word passes the entry register, one register per cell of the
// division chain, then the final rounding/saturation register.
// Throughput is one word per cycle, set by the chain of division cells:
// each cell resolves one quotient bit and passes its partial remainder on.
// The quotient of |a| * 2^FRAC_BITS by |b| needs 32 + FRAC_BITS bits;
// the upper quotient bits beyond 32 only show up as overflow, so the chain
// computes all of them and flags any set high bit as saturation.
// The multiply product is formed in the entry stage and delayed with the
// word, so the multiplier lies between the input ports and the entry register.
// Reset clears the valid bits of the chain; no result comes out of it.
module fixed_point_alu import fpa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_word,
    output logic o_busy,
    output logic o_done,
    output t_out o_word
);
    localparam int STEPS = W + FRAC_BITS;

    t_ctx             c_ctx [STEPS+1];
    logic [MAG_W-1:0] c_rem [STEPS+1];
    logic [MAG_W-1:0] c_num [STEPS+1];
    logic [W-1:0]     c_quo [STEPS+1];
    logic [STEPS-1:0] r_qhi [STEPS+1];
    // Product rides along the chain so the multiplier needs only one stage.
    logic [MAG_W-1:0] r_prod [STEPS+1];
    logic [W-1:0]     mag_a;
    logic [W-1:0]     mag_b;

    assign o_busy = 1'b0;
    assign mag_a  = (i_word.operand_a < 0) ? -i_word.operand_a : i_word.operand_a;
    assign mag_b  = (i_word.operand_b < 0) ? -i_word.operand_b : i_word.operand_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctx[0].valid <= 1'b0;
        end else begin
            c_ctx[0].valid <= i_start;
        end
        c_ctx[0].kind <= i_word.kind;
        c_ctx[0].a    <= i_word.operand_a;
        c_ctx[0].b    <= i_word.operand_b;
        c_ctx[0].neg  <= (i_word.operand_a < 0) != (i_word.operand_b < 0);
        c_rem[0]      <= '0;
        c_num[0]      <= {{(MAG_W-W-FRAC_BITS){1'b0}}, mag_a, {FRAC_BITS{1'b0}}}
                         << (MAG_W - STEPS);
        c_quo[0]      <= '0;
        r_qhi[0]      <= '0;
        r_prod[0]     <= {{(MAG_W-W){1'b0}}, mag_a} * {{(MAG_W-W){1'b0}}, mag_b};
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_chain
        fpa_cell u_cell (
            .i_clk (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctx (c_ctx[g]),
            .i_rem (c_rem[g]),
            .i_num (c_num[g]),
            .i_quo (c_quo[g]),
            .o_ctx (c_ctx[g+1]),
            .o_rem (c_rem[g+1]),
            .o_num (c_num[g+1]),
            .o_quo (c_quo[g+1])
        );
        // Bits shifted out of the 32-bit quotient register mark overflow.
        always_ff @(posedge i_clk) begin
            r_qhi[g+1]  <= {r_qhi[g][STEPS-2:0], c_quo[g][W-1]};
            r_prod[g+1] <= r_prod[g];
        end
    end

    t_ctx             e;
    logic [MAG_W-1:0] dmag;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] pm;
    logic [MAG_W:0]   qfull;
    logic signed [65:0] x;
    t_out             n_out;

    always_comb begin
        e     = c_ctx[STEPS];
        dmag  = {{(MAG_W-W){1'b0}}, (e.b < 0) ? -e.b : e.b};
        rem   = c_rem[STEPS];
        pm    = (r_prod[STEPS] + (MAG_W'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        qfull = {1'b0, {(MAG_W-W){1'b0}}, c_quo[STEPS]};
        if (r_qhi[STEPS] != '0) begin
            qfull = {1'b0, {(MAG_W-W-1){1'b0}}, 1'b1, {W{1'b0}}};
        end
        if (rem >= dmag - rem) begin
            qfull = qfull + 1'b1;
        end
        n_out.a_less    = e.a < e.b;
        n_out.a_equal   = e.a == e.b;
        n_out.a_greater = e.a > e.b;
        n_out.status    = ST_OK;
        n_out.result_raw = e.a;
        x = '0;
        unique case (e.kind)
            K_ADD:     n_out = sat(66'(e.a) + 66'(e.b), n_out);
            K_SUB:     n_out = sat(66'(e.a) - 66'(e.b), n_out);
            K_MUL: begin
                x = e.neg ? -$signed({2'b00, pm}) : $signed({2'b00, pm});
                n_out = sat(x, n_out);
            end
            K_DIV: begin
                if (e.b == 0) begin
                    n_out.result_raw = '0;
                    n_out.status = ST_DIVZ;
                end else begin
                    x = e.neg ? -$signed({1'b0, qfull}) : $signed({1'b0, qfull});
                    n_out = sat(x, n_out);
                end
            end
            K_MIN:     n_out.result_raw = (e.a < e.b) ? e.a : e.b;
            K_MAX:     n_out.result_raw = (e.a > e.b) ? e.a : e.b;
            K_INC:     n_out = sat(66'(e.a) + 66'sd1, n_out);
            K_DEC:     n_out = sat(66'(e.a) - 66'sd1, n_out);
            K_TOINT:   n_out.result_raw = e.a >>> FRAC_BITS;
            K_FROMINT: n_out = sat(66'(e.a) <<< FRAC_BITS, n_out);
            default:   n_out.result_raw = e.a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= e.valid;
        end
        o_word <= n_out;
    end
endmodule

// ----- rtl/core/fpa_checker.sv -----
module fpa_checker import fpa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_busy,
    input logic o_done,
    input t_out o_word
);
    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot({o_word.a_less, o_word.a_equal, o_word.a_greater}))
        else $error("compare flags not one-hot");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_word.status != 2'd3))
        else $error("bad status");
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_word.status == ST_DIVZ) |-> (o_word.result_raw == 0))
        else $error("divide by zero result not zero");
    a_reset_done: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("done after reset");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_busy(o_busy), .o_done(o_done), .o_word(o_word)
);
